@@ sv/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg
// Opcodes, status codes, controller states and the command and status
// bundles that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package rau_pkg;

  localparam logic [3:0] FN_ADD  = 4'd0;
  localparam logic [3:0] FN_SUB  = 4'd1;
  localparam logic [3:0] FN_MUL  = 4'd2;
  localparam logic [3:0] FN_DIV  = 4'd3;
  localparam logic [3:0] FN_EQ   = 4'd4;
  localparam logic [3:0] FN_NE   = 4'd5;
  localparam logic [3:0] FN_LT   = 4'd6;
  localparam logic [3:0] FN_LE   = 4'd7;
  localparam logic [3:0] FN_GT   = 4'd8;
  localparam logic [3:0] FN_GE   = 4'd9;
  localparam logic [3:0] FN_NEG  = 4'd10;
  localparam logic [3:0] FN_INC  = 4'd11;
  localparam logic [3:0] FN_DEC  = 4'd12;
  localparam logic [3:0] FN_NORM = 4'd13;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_ZERO  = 2'd1;
  localparam logic [1:0] ST_NONCA = 2'd2;
  localparam logic [1:0] ST_OVF   = 2'd3;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHKA,
    S_CHKA_RUN,
    S_CHKB,
    S_CHKB_RUN,
    S_MUL0,
    S_MUL1,
    S_MUL2,
    S_FORM,
    S_RED,
    S_RED_RUN,
    S_DIV_RUN,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic       load;
    logic       gcd_ld_a;
    logic       gcd_ld_b;
    logic       gcd_ld_r;
    logic       gcd_step;
    logic       mul_en;
    logic [1:0] mul_idx;
    logic       form;
    logic       div_ld;
    logic       div_step;
    logic       emit;
    logic [1:0] err;
  } cmd_t;

  typedef struct packed {
    logic [3:0] func;
    logic       norm_den_zero;
    logic       norm_fits;
    logic       a_pre_ok;
    logic       a_zero;
    logic       b_pre_ok;
    logic       b_zero;
    logic       gcd_done;
    logic       gcd_one;
    logic       mag_zero;
    logic       div_done;
    logic       out_free;
  } stat_t;

endpackage

@@ sv/rau_dp.sv @@
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, shared 32x32 multiplier, binary gcd unit,
// two-lane restoring divider and the result register.
// ----------------------------------------------------------------------------
module rau_dp
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  cmd_t               cmd,
  output stat_t              st,
  input  logic [3:0]         in_func,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic               out_compare_true,
  output logic [1:0]         out_status
);

  localparam logic [63:0] LIM = 64'(1) << (WIDTH - 1);

  function automatic logic fits_w(input logic signed [31:0] x);
    logic signed [31:0] s;
    s = x >>> (WIDTH - 1);
    return (s == '0) || (s == '1);
  endfunction

  function automatic logic [63:0] mag32(input logic signed [31:0] x);
    logic signed [63:0] e;
    e = 64'(x);
    return e[63] ? 64'(-e) : 64'(e);
  endfunction

  logic [3:0]         func_r;
  logic signed [31:0] an_r, ad_r, bn_r, bd_r;
  logic signed [63:0] p0_r, p1_r, p2_r;
  logic               neg_r, cmp_r;
  logic [63:0]        mn_r, md_r;
  logic [63:0]        ga_r, gb_r, gdiv_r;
  logic [5:0]         gsh_r;
  logic [63:0]        qn_r, qd_r, rn_r, rd_r;
  logic [6:0]         dcnt_r;
  logic signed [31:0] num_r;
  logic [30:0]        den_r;
  logic               ct_r;
  logic [1:0]         sts_r;

  // multiplier
  logic signed [31:0] mx, my;
  logic signed [63:0] prod;

  always_comb begin
    unique case (cmd.mul_idx)
      2'd0: begin
        mx = an_r;
        my = (func_r == FN_MUL) ? bn_r : bd_r;
      end
      2'd1: begin
        mx = ad_r;
        my = bn_r;
      end
      default: begin
        mx = ad_r;
        my = bd_r;
      end
    endcase
    prod = mx * my;
  end

  // numerator/denominator forming
  logic signed [65:0] sn, sd;
  logic               cmp_c;

  always_comb begin
    sn = 66'sd0;
    sd = 66'sd1;
    unique case (func_r)
      FN_ADD: begin sn = 66'(p0_r) + 66'(p1_r); sd = 66'(p2_r); end
      FN_SUB: begin sn = 66'(p0_r) - 66'(p1_r); sd = 66'(p2_r); end
      FN_MUL: begin sn = 66'(p0_r); sd = 66'(p2_r); end
      FN_DIV: begin
        if (p1_r < 0) begin
          sn = -66'(p0_r);
          sd = -66'(p1_r);
        end else begin
          sn = 66'(p0_r);
          sd = 66'(p1_r);
        end
      end
      FN_NEG: begin sn = -66'(an_r); sd = 66'(ad_r); end
      FN_INC: begin sn = 66'(an_r) + 66'(ad_r); sd = 66'(ad_r); end
      FN_DEC: begin sn = 66'(an_r) - 66'(ad_r); sd = 66'(ad_r); end
      FN_NORM: begin
        if (ad_r < 0) begin
          sn = -66'(an_r);
          sd = -66'(ad_r);
        end else begin
          sn = 66'(an_r);
          sd = 66'(ad_r);
        end
      end
      default: begin sn = 66'sd0; sd = 66'sd1; end
    endcase
    unique case (func_r)
      FN_EQ:   cmp_c = (an_r == bn_r) && (ad_r == bd_r);
      FN_NE:   cmp_c = !((an_r == bn_r) && (ad_r == bd_r));
      FN_LT:   cmp_c = p0_r < p1_r;
      FN_LE:   cmp_c = p0_r <= p1_r;
      FN_GT:   cmp_c = p0_r > p1_r;
      FN_GE:   cmp_c = p0_r >= p1_r;
      default: cmp_c = 1'b0;
    endcase
  end

  // gcd step
  logic [63:0] g_diff_ab, g_diff_ba, gval;
  assign g_diff_ab = ga_r - gb_r;
  assign g_diff_ba = gb_r - ga_r;
  assign gval      = ga_r << gsh_r;

  // divider lanes
  logic [64:0] rn_sh, rd_sh;
  logic        gen, ged;
  assign rn_sh = {rn_r, qn_r[63]};
  assign rd_sh = {rd_r, qd_r[63]};
  assign gen   = rn_sh >= {1'b0, gdiv_r};
  assign ged   = rd_sh >= {1'b0, gdiv_r};

  logic [63:0] rn_sub, rd_sub;
  assign rn_sub = 64'(rn_sh - {1'b0, gdiv_r});
  assign rd_sub = 64'(rd_sh - {1'b0, gdiv_r});

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      an_r   <= in_a_num;
      ad_r   <= in_a_den;
      bn_r   <= in_b_num;
      bd_r   <= in_b_den;
    end
    if (cmd.mul_en) begin
      unique case (cmd.mul_idx)
        2'd0:    p0_r <= prod;
        2'd1:    p1_r <= prod;
        default: p2_r <= prod;
      endcase
    end
    if (cmd.form) begin
      neg_r <= sn < 0;
      mn_r  <= (sn < 0) ? 64'(-sn) : 64'(sn);
      md_r  <= 64'(sd);
      cmp_r <= cmp_c;
    end
    priority if (cmd.gcd_ld_a) begin
      ga_r  <= mag32(an_r);
      gb_r  <= 64'(ad_r);
      gsh_r <= '0;
    end else if (cmd.gcd_ld_b) begin
      ga_r  <= mag32(bn_r);
      gb_r  <= 64'(bd_r);
      gsh_r <= '0;
    end else if (cmd.gcd_ld_r) begin
      ga_r  <= mn_r;
      gb_r  <= md_r;
      gsh_r <= '0;
    end else if (cmd.gcd_step && (ga_r != gb_r)) begin
      priority if (!ga_r[0] && !gb_r[0]) begin
        ga_r  <= ga_r >> 1;
        gb_r  <= gb_r >> 1;
        gsh_r <= gsh_r + 6'd1;
      end else if (!ga_r[0]) begin
        ga_r <= ga_r >> 1;
      end else if (!gb_r[0]) begin
        gb_r <= gb_r >> 1;
      end else if (ga_r > gb_r) begin
        ga_r <= g_diff_ab >> 1;
      end else begin
        gb_r <= g_diff_ba >> 1;
      end
    end
    if (cmd.div_ld) begin
      gdiv_r <= gval;
      qn_r   <= mn_r;
      qd_r   <= md_r;
      rn_r   <= '0;
      rd_r   <= '0;
    end else if (cmd.div_step) begin
      qn_r <= {qn_r[62:0], gen};
      qd_r <= {qd_r[62:0], ged};
      rn_r <= gen ? rn_sub : rn_sh[63:0];
      rd_r <= ged ? rd_sub : rd_sh[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dcnt_r <= '0;
    end else if (cmd.div_ld) begin
      dcnt_r <= '0;
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + 7'd1;
    end
  end

  // result formatting
  logic is_cmp;
  logic ovf;
  assign is_cmp = (func_r >= FN_EQ) && (func_r <= FN_GE);
  assign ovf    = (qd_r > LIM - 64'd1) ||
                  (neg_r ? (qn_r > LIM) : (qn_r > LIM - 64'd1));

  logic signed [31:0] num_nxt;
  logic [30:0]        den_nxt;
  logic               ct_nxt;
  logic [1:0]         sts_nxt;

  always_comb begin
    num_nxt = '0;
    den_nxt = 31'd1;
    ct_nxt  = 1'b0;
    sts_nxt = ST_OK;
    priority if (cmd.err != ST_OK) begin
      sts_nxt = cmd.err;
    end else if (is_cmp) begin
      ct_nxt = cmp_r;
    end else if (mn_r == '0) begin
      sts_nxt = ST_OK;
    end else if (ovf) begin
      sts_nxt = ST_OVF;
    end else begin
      num_nxt = neg_r ? -qn_r[31:0] : qn_r[31:0];
      den_nxt = qd_r[30:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      num_r <= num_nxt;
      den_r <= den_nxt;
      ct_r  <= ct_nxt;
      sts_r <= sts_nxt;
    end
  end

  assign out_res_num      = num_r;
  assign out_res_den      = den_r;
  assign out_compare_true = ct_r;
  assign out_status       = sts_r;

  assign st.func          = func_r;
  assign st.norm_den_zero = ad_r == '0;
  assign st.norm_fits     = fits_w(an_r) && fits_w(ad_r);
  assign st.a_pre_ok      = fits_w(an_r) && fits_w(ad_r) && (ad_r > 0) &&
                            ((an_r != '0) || (ad_r == 32'sd1));
  assign st.a_zero        = an_r == '0;
  assign st.b_pre_ok      = fits_w(bn_r) && fits_w(bd_r) && (bd_r > 0) &&
                            ((bn_r != '0) || (bd_r == 32'sd1));
  assign st.b_zero        = bn_r == '0;
  assign st.gcd_done      = ga_r == gb_r;
  assign st.gcd_one       = (ga_r == 64'd1) && (gsh_r == '0);
  assign st.mag_zero      = mn_r == '0;
  assign st.div_done      = dcnt_r == 7'd64;
  assign st.out_free      = !out_valid || out_ready;

endmodule

@@ sv/rau_ctrl.sv @@
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: operand checks, products, reduction gcd, exact divide, emit.
// ----------------------------------------------------------------------------
module rau_ctrl
  import rau_pkg::*;
(
  input  logic  clk,
  input  logic  rst_n,
  input  logic  in_valid,
  output logic  in_ready,
  input  stat_t st,
  output cmd_t  cmd
);

  state_t     state_r, state_nxt;
  logic [1:0] err_r, err_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      err_r   <= ST_OK;
    end else begin
      state_r <= state_nxt;
      err_r   <= err_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    err_nxt   = err_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          state_nxt = S_CHKA;
          err_nxt   = ST_OK;
        end
      end
      S_CHKA: begin
        priority if (st.func == FN_NORM) begin
          priority if (st.norm_den_zero) begin
            err_nxt = ST_ZERO; state_nxt = S_EMIT;
          end else if (!st.norm_fits) begin
            err_nxt = ST_NONCA; state_nxt = S_EMIT;
          end else begin
            state_nxt = S_FORM;
          end
        end else if (st.func > FN_NORM || !st.a_pre_ok) begin
          err_nxt = ST_NONCA; state_nxt = S_EMIT;
        end else if (st.a_zero) begin
          state_nxt = S_CHKB;
        end else begin
          state_nxt = S_CHKA_RUN;
        end
      end
      S_CHKA_RUN: begin
        if (st.gcd_done) begin
          if (st.gcd_one) begin
            state_nxt = S_CHKB;
          end else begin
            err_nxt = ST_NONCA; state_nxt = S_EMIT;
          end
        end
      end
      S_CHKB: begin
        priority if (st.func >= FN_NEG) begin
          state_nxt = S_FORM;
        end else if (!st.b_pre_ok) begin
          err_nxt = ST_NONCA; state_nxt = S_EMIT;
        end else if (st.b_zero) begin
          if (st.func == FN_DIV) begin
            err_nxt = ST_ZERO; state_nxt = S_EMIT;
          end else begin
            state_nxt = S_MUL0;
          end
        end else begin
          state_nxt = S_CHKB_RUN;
        end
      end
      S_CHKB_RUN: begin
        if (st.gcd_done) begin
          if (st.gcd_one) begin
            state_nxt = S_MUL0;
          end else begin
            err_nxt = ST_NONCA; state_nxt = S_EMIT;
          end
        end
      end
      S_MUL0: state_nxt = S_MUL1;
      S_MUL1: state_nxt = S_MUL2;
      S_MUL2: state_nxt = S_FORM;
      S_FORM: begin
        if ((st.func >= FN_EQ) && (st.func <= FN_GE)) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_RED;
        end
      end
      S_RED: begin
        state_nxt = st.mag_zero ? S_EMIT : S_RED_RUN;
      end
      S_RED_RUN: begin
        if (st.gcd_done) state_nxt = S_DIV_RUN;
      end
      S_DIV_RUN: begin
        if (st.div_done) state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (st.out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    cmd      = '0;
    cmd.err  = err_r;
    in_ready = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      S_CHKA: begin
        cmd.gcd_ld_a = (st.func < FN_NORM) && st.a_pre_ok && !st.a_zero;
      end
      S_CHKA_RUN: cmd.gcd_step = 1'b1;
      S_CHKB: begin
        cmd.gcd_ld_b = (st.func < FN_NEG) && st.b_pre_ok && !st.b_zero;
      end
      S_CHKB_RUN: cmd.gcd_step = 1'b1;
      S_MUL0: begin cmd.mul_en = 1'b1; cmd.mul_idx = 2'd0; end
      S_MUL1: begin cmd.mul_en = 1'b1; cmd.mul_idx = 2'd1; end
      S_MUL2: begin cmd.mul_en = 1'b1; cmd.mul_idx = 2'd2; end
      S_FORM: cmd.form = 1'b1;
      S_RED:  cmd.gcd_ld_r = !st.mag_zero;
      S_RED_RUN: begin
        cmd.gcd_step = !st.gcd_done;
        cmd.div_ld   = st.gcd_done;
      end
      S_DIV_RUN: cmd.div_step = !st.div_done;
      S_EMIT:    cmd.emit = st.out_free;
      default: ;
    endcase
  end

  a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> st.out_free)
    else $error("result written over a pending beat");

  a_emit_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |=> state_r == S_IDLE)
    else $error("controller did not return to idle after emit");

  a_one_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.load, cmd.gcd_ld_a, cmd.gcd_ld_b, cmd.gcd_ld_r, cmd.gcd_step,
              cmd.mul_en, cmd.form, cmd.div_ld, cmd.div_step, cmd.emit}))
    else $error("more than one datapath operation in a cycle");

endmodule

@@ sv/rational_arithmetic_unit_core.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit_core
// Rational add/sub/mul/div, compares, neg/inc/dec and normalize with
// gcd-reduced results and a status code.
// Sequence: accept, a check (load, gcd steps), b check (load, gcd steps),
// 3 products, form, reduce load, reduce gcd steps, divide, emit. A gcd step
// drops at least one bit. One item at a time: the next beat is taken once
// the sequencer is idle, while the previous result may still wait in the
// output register.
// Reset: synchronous active-low rst_n clears the sequencer and out_valid.
// ----------------------------------------------------------------------------
module rational_arithmetic_unit_core
  import rau_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [3:0]         in_func,
  input  logic signed [31:0] in_a_num,
  input  logic signed [31:0] in_a_den,
  input  logic signed [31:0] in_b_num,
  input  logic signed [31:0] in_b_den,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] out_res_num,
  output logic [30:0]        out_res_den,
  output logic               out_compare_true,
  output logic [1:0]         out_status
);

  // Controller issues at most one datapath operation per cycle; the datapath reports
  // operand checks, gcd/divider completion and output-slot availability.
  cmd_t  cmd;
  stat_t st;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: 32x32 multiplier shared over the three products, binary gcd at one
  // step per cycle, divider retiring one quotient bit per cycle on both lanes.
  rau_dp #(
    .WIDTH (WIDTH)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .st               (st),
    .in_func          (in_func),
    .in_a_num         (in_a_num),
    .in_a_den         (in_a_den),
    .in_b_num         (in_b_num),
    .in_b_den         (in_b_den),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_res_num      (out_res_num),
    .out_res_den      (out_res_den),
    .out_compare_true (out_compare_true),
    .out_status       (out_status)
  );

  // Any error beat carries 0/1 and no compare flag.
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_status != ST_OK)) |->
      ((out_res_num == '0) && (out_res_den == 31'd1) && !out_compare_true))
    else $error("error beat with nonzero payload");

  // Denominator of a delivered beat is never zero.
  a_den_pos: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_res_den != '0))
    else $error("zero denominator in result beat");

  // A stalled beat holds until taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_res_num) && $stable(out_res_den) &&
       $stable(out_compare_true) && $stable(out_status)))
    else $error("result beat changed while stalled");

endmodule

@@ sim/tb_rational_arithmetic_unit_core.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_rational_arithmetic_unit_core
// Drives rational operations through the unit with random input gaps and
// output stalls, predicts each reduced result in-bench and checks it beat
// by beat against a queue of expected results.
// ----------------------------------------------------------------------------
module tb_rational_arithmetic_unit_core
  import rau_pkg::*;
();

  localparam int W = 32;

  // one expected result beat
  typedef struct {
    logic signed [31:0] num;
    logic [30:0]        den;
    logic               cmp;
    logic [1:0]         st;
  } rat_res_t;

  // scoreboard: predicts the reduced fraction for each input beat
  class rat_scoreboard;
    rat_res_t pending[$];
    int       mismatches;
    int       checked;

    function bit fits(longint x);
      longint hi;
      hi = (64'sd1 <<< (W - 1)) - 1;
      return x >= -hi - 1 && x <= hi;
    endfunction

    function longint unsigned absval(longint x);
      return x < 0 ? 64'd0 - longint'(x) : x;
    endfunction

    // Euclid is fine here; only the value matters
    function longint unsigned gcd64(longint unsigned a, longint unsigned b);
      longint unsigned t;
      while (b != 0) begin
        t = a % b;
        a = b;
        b = t;
      end
      return a;
    endfunction

    function bit is_canon(longint n, longint d);
      if (!fits(n) || !fits(d) || d <= 0) return 0;
      if (n == 0) return d == 1;
      return gcd64(absval(n), d) == 1;
    endfunction

    function rat_res_t err_res(logic [1:0] st);
      rat_res_t r;
      r.num = 0; r.den = 1; r.cmp = 0; r.st = st;
      return r;
    endfunction

    function rat_res_t reduce(longint n, longint d);
      rat_res_t        r;
      longint unsigned mn, md, g, lim;
      bit              ng;
      if (n == 0) return err_res(ST_OK);
      ng = n < 0;
      mn = absval(n);
      md = d;
      g = gcd64(mn, md);
      mn = mn / g;
      md = md / g;
      lim = 64'd1 << (W - 1);
      if (md > lim - 1 || (ng ? mn > lim : mn > lim - 1)) return err_res(ST_OVF);
      r.num = 32'(ng ? -longint'(mn) : longint'(mn));
      r.den = md[30:0];
      r.cmp = 0;
      r.st = ST_OK;
      return r;
    endfunction

    function rat_res_t predict(logic [3:0] f, logic signed [31:0] an32,
                               logic signed [31:0] ad32, logic signed [31:0] bn32,
                               logic signed [31:0] bd32);
      longint   an, ad, bn, bd, l, r;
      bit       c;
      rat_res_t res;
      an = an32; ad = ad32; bn = bn32; bd = bd32;
      if (f == FN_NORM) begin
        if (ad == 0) return err_res(ST_ZERO);
        if (!fits(an) || !fits(ad)) return err_res(ST_NONCA);
        if (ad < 0) begin
          an = -an;
          ad = -ad;
        end
        return reduce(an, ad);
      end
      if (f > FN_NORM || !is_canon(an, ad) || (f < FN_NEG && !is_canon(bn, bd)))
        return err_res(ST_NONCA);
      case (f)
        FN_ADD: return reduce(an * bd + ad * bn, ad * bd);
        FN_SUB: return reduce(an * bd - ad * bn, ad * bd);
        FN_MUL: return reduce(an * bn, ad * bd);
        FN_DIV: begin
          if (bn == 0) return err_res(ST_ZERO);
          l = an * bd;
          r = ad * bn;
          if (r < 0) begin
            l = -l;
            r = -r;
          end
          return reduce(l, r);
        end
        FN_NEG: return reduce(-an, ad);
        FN_INC: return reduce(an + ad, ad);
        FN_DEC: return reduce(an - ad, ad);
        default: ;
      endcase
      l = an * bd;
      r = bn * ad;
      case (f)
        FN_EQ:   c = (an == bn) && (ad == bd);
        FN_NE:   c = !((an == bn) && (ad == bd));
        FN_LT:   c = l < r;
        FN_LE:   c = l <= r;
        FN_GT:   c = l > r;
        default: c = l >= r;
      endcase
      res = err_res(ST_OK);
      res.cmp = c;
      return res;
    endfunction

    function void note_input(logic [3:0] f, logic signed [31:0] an,
                             logic signed [31:0] ad, logic signed [31:0] bn,
                             logic signed [31:0] bd);
      pending.push_back(predict(f, an, ad, bn, bd));
    endfunction

    function void check_result(logic signed [31:0] num, logic [30:0] den,
                               logic cmp, logic [1:0] st);
      rat_res_t e;
      checked++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("ERROR: result beat with nothing expected");
        return;
      end
      e = pending.pop_front();
      if (num !== e.num || den !== e.den || cmp !== e.cmp || st !== e.st) begin
        mismatches++;
        if (mismatches <= 10)
          $display({"ERROR: exp num=%0d den=%0d cmp=%0b st=%0d, ",
                    "got num=%0d den=%0d cmp=%0b st=%0d"},
                   e.num, e.den, e.cmp, e.st, num, den, cmp, st);
      end
    endfunction
  endclass

  logic               clk = 0;
  logic               rst_n = 0;
  logic               in_valid = 0;
  logic               in_ready;
  logic [3:0]         in_func = 0;
  logic signed [31:0] in_a_num = 0;
  logic signed [31:0] in_a_den = 1;
  logic signed [31:0] in_b_num = 0;
  logic signed [31:0] in_b_den = 1;
  logic               out_valid;
  logic               out_ready = 0;
  logic signed [31:0] out_res_num;
  logic [30:0]        out_res_den;
  logic               out_compare_true;
  logic [1:0]         out_status;

  rat_scoreboard sb = new();
  longint        cycles = 0;
  int            sent = 0;
  bit            stall_burst = 0;
  // run-time bound: 2000+ items plus stalls, times margin
  localparam longint CYCLE_LIMIT = 4_000_000;

  always #6 clk = ~clk;

  rational_arithmetic_unit_core #(.WIDTH(W)) uut (.*);

  // receiver: stalls in runs, sometimes long stretches ready
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (rst_n && out_valid && out_ready)
      sb.check_result(out_res_num, out_res_den, out_compare_true, out_status);
    if ($urandom_range(0, 63) == 0) stall_burst <= ~stall_burst;
    out_ready <= stall_burst ? ($urandom_range(0, 3) == 0) : ($urandom_range(0, 7) != 0);
  end

  always @(posedge clk) begin
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles", cycles);
      $display("Simulation FAILED");
      $finish;
    end
  end

  // present one beat and hold it until accepted
  task automatic send_op(logic [3:0] f, logic signed [31:0] an, logic signed [31:0] ad,
                         logic signed [31:0] bn, logic signed [31:0] bd);
    in_valid <= 1;
    in_func <= f;
    in_a_num <= an;
    in_a_den <= ad;
    in_b_num <= bn;
    in_b_den <= bd;
    do @(posedge clk); while (!in_ready);
    sb.note_input(f, an, ad, bn, bd);
    sent++;
  endtask

  task automatic idle_gap(int n);
    if (n > 0) begin
      in_valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  // small value with random sign, zero, a full-range random value or an extreme
  function automatic logic signed [31:0] pick_num();
    case ($urandom_range(0, 9))
      0: return 32'sh8000_0000;
      1: return 32'sh7fff_ffff;
      2: return 0;
      3, 4: return $urandom();
      default: return $signed($urandom_range(0, 2000)) - 1000;
    endcase
  endfunction

  function automatic logic signed [31:0] pick_den();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 1;
      2: return $urandom() >> 1;
      default: return $urandom_range(1, 1000);
    endcase
  endfunction

  // reduce so that most operands are canonical
  function automatic void canonize(inout logic signed [31:0] n, inout logic signed [31:0] d);
    longint unsigned g;
    if (n == 0) begin
      d = 1;
      return;
    end
    g = sb.gcd64(sb.absval(n), d);
    if (g > 1 && !(n == 32'sh8000_0000 && g == 64'd2147483648)) begin
      n = 32'(n / longint'(g));
      d = 32'(d / longint'(g));
    end
  endfunction

  initial begin
    logic signed [31:0] an, ad, bn, bd;
    logic [3:0]         f;
    int                 burst;
    repeat (8) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: every opcode, extremes and the special cases
    for (int k = 0; k <= 13; k++) send_op(k[3:0], 3, 4, -5, 6);
    send_op(FN_DIV, 1, 2, 0, 1);                         // zero divisor
    send_op(FN_DIV, 3, 4, -5, 7);                        // negative quotient den
    send_op(FN_NORM, 5, 0, 0, 1);                        // normalize zero den
    send_op(FN_NORM, 32'sh8000_0000, -1, 0, 1);          // overflow on normalize
    send_op(FN_NORM, -6, -4, 0, 1);                      // sign moves to num
    send_op(FN_ADD, 32'sh7fff_ffff, 1, 1, 1);            // overflow
    send_op(FN_MUL, 32'sh8000_0000, 1, -1, 1);           // overflow
    send_op(FN_EQ, 1, 2, 1, 3);                          // equal num, unequal den
    send_op(FN_ADD, 2, 4, 1, 3);                         // non-canonical a
    send_op(4'd14, 1, 1, 1, 1);                          // unused opcodes
    send_op(4'd15, 1, 1, 1, 1);

    // random: mostly canonical operands in bursts with gaps
    while (sent < 2025) begin
      burst = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 12);
      for (int k = 0; k < burst; k++) begin
        f = ($urandom_range(0, 31) == 0) ? 4'($urandom_range(14, 15)) : 4'($urandom_range(0, 13));
        an = pick_num(); ad = pick_den(); bn = pick_num(); bd = pick_den();
        if ($urandom_range(0, 9) != 0) begin
          canonize(an, ad);
          canonize(bn, bd);
        end
        if ($urandom_range(0, 15) == 0) ad = $urandom();
        if ($urandom_range(0, 15) == 0) bd = $urandom();
        if (f == FN_NORM && $urandom_range(0, 1)) ad = -ad;
        if ($urandom_range(0, 7) == 0) begin
          bn = an;
          bd = ad;
        end
        send_op(f, an, ad, bn, bd);
      end
      idle_gap($urandom_range(0, 3) == 0 ? $urandom_range(1, 500) : $urandom_range(0, 4));
    end
    in_valid <= 0;

    while (sb.pending.size() != 0) @(posedge clk);
    repeat (500) @(posedge clk);
    $display("Sent %0d operations over all 16 opcodes, checked %0d result beats,",
             sent, sb.checked);
    $display("with canonical, non-canonical, overflow and zero-divisor operands.");
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", sb.mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
